// ===== rtl/acas_pkg.sv =====
// Shared types and constants of the aligned copy access splitter.
package acas_pkg;

    localparam int GROUP_W      = 13;
    localparam int ALIGN_W      = 3;
    localparam int ALIGN_MASK_W = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 3'd3;
    localparam logic [GROUP_W-1:0] GROUP_RESET = 13'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_BODY_ALIGN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_BYTES = 2'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic KIND_SINGLE = 1'b0;
    localparam logic KIND_BODY   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_TAIL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SZ_1 = 2'd0,
        SZ_2 = 2'd1,
        SZ_4 = 2'd2,
        SZ_8 = 2'd3
    } size_code_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } seq_state_t;

endpackage

// ===== rtl/acas_if.sv =====
// Channel interfaces: request, command and configuration write.
interface acas_req_if #(
    parameter int ADDR_W = 48,
    parameter int LEN_W  = 24
);
    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] dst_address;
    logic [ADDR_W-1:0] src_address;
    logic [LEN_W-1:0]  length;
    logic              direction;
    logic              body_enable;

    modport source (
        output valid, operation, dst_address, src_address, length, direction, body_enable,
        input  ready
    );
    modport sink (
        input  valid, operation, dst_address, src_address, length, direction, body_enable,
        output ready
    );
endinterface

interface acas_cmd_if #(
    parameter int ADDR_W = 48,
    parameter int LEN_W  = 24
);
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cmd_dst_address;
    logic [ADDR_W-1:0] cmd_src_address;
    logic              cmd_kind;
    logic [1:0]        access_size_code;
    logic [LEN_W-1:0]  body_length;
    logic              cmd_direction;
    logic              last;

    modport source (
        output valid, cmd_dst_address, cmd_src_address, cmd_kind, access_size_code,
               body_length, cmd_direction, last,
        input  ready
    );
    modport sink (
        input  valid, cmd_dst_address, cmd_src_address, cmd_kind, access_size_code,
               body_length, cmd_direction, last,
        output ready
    );
endinterface

interface acas_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/acas_size_pick.sv =====
// Single access size selection: largest aligned power of two up to 8 bytes that does not exceed the remaining length.
module acas_size_pick #(
    parameter int LEN_W = 24
) (
    input  logic [2:0]              dev_low,
    input  logic [LEN_W-1:0]        remaining,
    output acas_pkg::size_code_t    code
);
    import acas_pkg::*;

    always_comb
    begin
        priority if (remaining >= LEN_W'(8) && dev_low == 3'b000)
            code = SZ_8;
        else if (remaining >= LEN_W'(4) && dev_low[1:0] == 2'b00)
            code = SZ_4;
        else if (remaining >= LEN_W'(2) && dev_low[0] == 1'b0)
            code = SZ_2;
        else
            code = SZ_1;
    end

endmodule

// ===== rtl/acas_rem_unit.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
module acas_rem_unit #(
    parameter int LEN_W = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [LEN_W-1:0]              dividend,
    input  logic [acas_pkg::GROUP_W-1:0]  divisor,
    output logic                          done,
    output logic [acas_pkg::GROUP_W-1:0]  remainder
);
    import acas_pkg::*;

    localparam int CNT_W = $clog2(LEN_W + 1);

    logic [GROUP_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [GROUP_W:0]   trial;
    logic [GROUP_W:0]   diff;

    // Shift in the next dividend bit and subtract when it fits.
    assign trial = {rem_reg, quo_reg[LEN_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(LEN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = diff[GROUP_W-1:0];
            else
                rem_next = trial[GROUP_W-1:0];
            quo_next = {quo_reg[LEN_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/aligned_copy_access_splitter_top.sv =====
// Aligned copy access splitter: turns a copy request into access commands.
// A load transfer only latches the request; a step that yields a single access
// passes accept (idle) and issue (emit); a step that yields the body block also
// waits in the divide state for the bit-serial remainder unit (one bit per cycle).
// One request item is in work at a time; the command register decouples issue.
// Reset (rst_n, async, active low): idle, no request, align log2 3, group 64.
module aligned_copy_access_splitter_top #(
    parameter int ADDR_W = 48,
    parameter int LEN_W  = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    acas_req_if.sink   req,
    acas_cmd_if.source cmd,
    acas_cfg_if.sink   cfg
);
    import acas_pkg::*;

    localparam int CMP_W = (LEN_W > GROUP_W) ? LEN_W : GROUP_W;

    // Sequencer and request state.
    seq_state_t          state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [ADDR_W-1:0]   cur_dst_reg, cur_dst_next;
    logic [ADDR_W-1:0]   cur_src_reg, cur_src_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic                dir_reg, dir_next;
    logic                body_en_reg, body_en_next;
    logic                kind_reg, kind_next;

    // Configuration registers.
    logic [ALIGN_W-1:0]  align_reg;
    logic [GROUP_W-1:0]  group_reg;

    // Command output register.
    logic                cmd_valid_reg, cmd_valid_next;
    logic [ADDR_W-1:0]   out_dst_reg, out_dst_next;
    logic [ADDR_W-1:0]   out_src_reg, out_src_next;
    logic                out_kind_reg, out_kind_next;
    logic [1:0]          out_code_reg, out_code_next;
    logic [LEN_W-1:0]    out_blen_reg, out_blen_next;
    logic                out_dir_reg, out_dir_next;
    logic                out_last_reg, out_last_next;

    logic                req_fire;
    logic                cfg_fire;
    logic [ADDR_W-1:0]   dev_addr;
    logic [ALIGN_MASK_W-1:0] align_mask;
    logic                head_aligned;
    logic                body_go;
    logic                div_start;
    logic                div_done;
    logic [GROUP_W-1:0]  div_rem;
    size_code_t          size_code;
    logic [LEN_W-1:0]    blen;
    logic [LEN_W-1:0]    step_len;
    logic [LEN_W-1:0]    rem_after;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // The device side of the copy sets the alignment of every access.
    assign dev_addr = dir_reg ? cur_dst_reg : cur_src_reg;

    // Head ends once the device address meets the body alignment.
    assign align_mask   = (ALIGN_MASK_W'(1) << align_reg) - ALIGN_MASK_W'(1);
    assign head_aligned = (dev_addr[ALIGN_MASK_W-1:0] & align_mask) == '0;

    // Body only when enabled, group nonzero and at least one whole group remains.
    assign body_go = (phase_reg == PH_HEAD) && head_aligned && body_en_reg
                     && (group_reg != '0)
                     && (CMP_W'(remaining_reg) >= CMP_W'(group_reg));

    acas_rem_unit #(
        .LEN_W (LEN_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (remaining_reg),
        .divisor   (group_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    acas_size_pick #(
        .LEN_W (LEN_W)
    ) u_size (
        .dev_low   (dev_addr[2:0]),
        .remaining (remaining_reg),
        .code      (size_code)
    );

    // Body length is the remaining count rounded down to whole groups.
    assign blen      = remaining_reg - LEN_W'(div_rem);
    assign step_len  = (kind_reg == KIND_BODY) ? blen : (LEN_W'(1) << size_code);
    assign rem_after = remaining_reg - step_len;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cur_dst_next   = cur_dst_reg;
        cur_src_next   = cur_src_reg;
        remaining_next = remaining_reg;
        dir_next       = dir_reg;
        body_en_next   = body_en_reg;
        kind_next      = kind_reg;
        div_start      = 1'b0;

        cmd_valid_next = cmd_valid_reg;
        out_dst_next   = out_dst_reg;
        out_src_next   = out_src_reg;
        out_kind_next  = out_kind_reg;
        out_code_next  = out_code_reg;
        out_blen_next  = out_blen_reg;
        out_dir_next   = out_dir_reg;
        out_last_next  = out_last_reg;

        // Drop the command once the sink takes the transfer.
        if (cmd_valid_reg && cmd.ready)
            cmd_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.operation == OP_LOAD)
                    begin
                        // Latch a new request; an empty one stays idle.
                        cur_dst_next   = req.dst_address;
                        cur_src_next   = req.src_address;
                        remaining_next = req.length;
                        dir_next       = req.direction;
                        body_en_next   = req.body_enable;
                        phase_next     = (req.length != '0) ? PH_HEAD : PH_IDLE;
                    end
                    else if (phase_reg == PH_IDLE || remaining_reg == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (phase_reg == PH_HEAD && head_aligned)
                            phase_next = PH_TAIL;
                        if (body_go)
                        begin
                            kind_next  = KIND_BODY;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            kind_next  = KIND_SINGLE;
                            state_next = S_EMIT;
                        end
                    end
                end
            end

            S_DIV:
            begin
                // Hold until the remainder is ready.
                if (div_done)
                    state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // Issue once the command register is free, then advance.
                if (!cmd_valid_reg || cmd.ready)
                begin
                    cmd_valid_next = 1'b1;
                    out_dst_next   = cur_dst_reg;
                    out_src_next   = cur_src_reg;
                    out_kind_next  = kind_reg;
                    out_code_next  = (kind_reg == KIND_BODY) ? SZ_1 : size_code;
                    out_blen_next  = (kind_reg == KIND_BODY) ? blen : '0;
                    out_dir_next   = dir_reg;
                    out_last_next  = (rem_after == '0);
                    cur_dst_next   = cur_dst_reg + ADDR_W'(step_len);
                    cur_src_next   = cur_src_reg + ADDR_W'(step_len);
                    remaining_next = rem_after;
                    if (rem_after == '0)
                        phase_next = PH_IDLE;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            cur_dst_reg   <= '0;
            cur_src_reg   <= '0;
            remaining_reg <= '0;
            dir_reg       <= 1'b0;
            body_en_reg   <= 1'b0;
            kind_reg      <= KIND_SINGLE;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cur_dst_reg   <= cur_dst_next;
            cur_src_reg   <= cur_src_next;
            remaining_reg <= remaining_next;
            dir_reg       <= dir_next;
            body_en_reg   <= body_en_next;
            kind_reg      <= kind_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= ALIGN_RESET;
            group_reg <= GROUP_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_BODY_ALIGN:  align_reg <= cfg.data[ALIGN_W-1:0];
                CFG_GROUP_BYTES: group_reg <= cfg.data[GROUP_W-1:0];
                default:
                begin
                    align_reg <= align_reg;
                    group_reg <= group_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_dst_reg  <= out_dst_next;
        out_src_reg  <= out_src_next;
        out_kind_reg <= out_kind_next;
        out_code_reg <= out_code_next;
        out_blen_reg <= out_blen_next;
        out_dir_reg  <= out_dir_next;
        out_last_reg <= out_last_next;
    end

    assign cmd.valid            = cmd_valid_reg;
    assign cmd.cmd_dst_address  = out_dst_reg;
    assign cmd.cmd_src_address  = out_src_reg;
    assign cmd.cmd_kind         = out_kind_reg;
    assign cmd.access_size_code = out_code_reg;
    assign cmd.body_length      = out_blen_reg;
    assign cmd.cmd_direction    = out_dir_reg;
    assign cmd.last             = out_last_reg;

endmodule
